// ===== hdl/assert_macros.svh =====
// assertion helpers included by the rtl unit
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication, checked at every rising clock edge out of reset
`define SIK_ASSERT_IMP(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("sik: check failed");

// next-cycle implication
`define SIK_ASSERT_NXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("sik: check failed");

`else

`define SIK_ASSERT_IMP(lbl, ante, cons)
`define SIK_ASSERT_NXT(lbl, ante, cons)

`endif

`endif

// ===== hdl/sik_pkg.sv =====
package sik_pkg;

   localparam int R_STEPS      = 24;
   localparam int DIV_STEPS    = 30;
   localparam int ACOS_STEPS   = 31;
   localparam int CORDIC_STEPS = 28;

   localparam logic signed [31:0] PI_Q28      = 32'sd843314857;
   localparam logic signed [31:0] TWO_PI_Q28  = 32'sd1686629713;
   localparam logic signed [31:0] HALF_PI_Q28 = 32'sd421657428;
   localparam logic signed [31:0] ONE_Q30     = 32'sd1073741824;
   localparam logic [61:0]        ONE_Q60     = 62'h1000_0000_0000_0000;

   localparam logic        CSR_UPPER  = 1'b0;
   localparam logic        CSR_LOWER  = 1'b1;
   localparam logic [22:0] LINK_RESET = 23'd204800;

   typedef struct packed {
      logic signed [23:0] x;
      logic signed [23:0] y;
   } pt_type;

   // digit-by-digit square root, two radicand bits per step
   typedef struct packed {
      logic [61:0] rad;
      logic [31:0] rem;
      logic [30:0] root;
   } sq_type;

   // restoring divider with the early-out cases folded into fix/one
   typedef struct packed {
      logic        neg;
      logic        fix;
      logic        one;
      logic [47:0] den;
      logic [47:0] rem;
      logic [29:0] q;
   } dv_type;

   typedef struct packed {
      logic signed [59:0] x;
      logic signed [59:0] y;
      logic signed [31:0] z;
   } cr_type;

   typedef struct packed {
      pt_type      pt;
      logic [46:0] xx;
      logic [46:0] yy;
      logic [45:0] aa;
      logic [45:0] bb;
      logic [45:0] ab;
   } mul_type;

   typedef struct packed {
      pt_type             pt;
      logic               r2z;
      logic [47:0]        r2;
      logic signed [49:0] num1;
      logic signed [49:0] num2;
      logic [47:0]        den1;
   } sum_type;

   typedef struct packed {
      pt_type             pt;
      logic               r2z;
      logic signed [49:0] num1;
      logic signed [49:0] num2;
      logic [47:0]        den1;
      sq_type             sq;
   } rs_type;

   typedef struct packed {
      pt_type             pt;
      logic               r2z;
      logic signed [49:0] num1;
      logic signed [49:0] num2;
      logic [47:0]        den1;
      logic [47:0]        den2;
   } dn_type;

   typedef struct packed {
      pt_type pt;
      logic   r2z;
      logic   clamp;
      dv_type d1;
      dv_type d2;
   } ds_type;

   typedef struct packed {
      pt_type             pt;
      logic               r2z;
      logic               clamp;
      logic signed [31:0] t1;
      logic signed [31:0] t2;
      logic [61:0]        tt1;
      logic [61:0]        tt2;
   } tq_type;

   typedef struct packed {
      pt_type             pt;
      logic               r2z;
      logic               clamp;
      logic signed [31:0] t1;
      logic signed [31:0] t2;
      sq_type             s1;
      sq_type             s2;
   } as_type;

   typedef struct packed {
      logic   r2z;
      logic   clamp;
      cr_type c1;
      cr_type c2;
      cr_type c3;
   } cs_type;

   function automatic sq_type sqrt_step(sq_type s);
      sq_type      o;
      logic [33:0] cur;
      logic [33:0] trial;
      cur   = {s.rem, s.rad[61:60]};
      trial = {1'b0, s.root, 2'b01};
      o.rad = {s.rad[59:0], 2'b00};
      if (cur >= trial) begin
         o.rem  = 32'(cur - trial);
         o.root = {s.root[29:0], 1'b1};
      end else begin
         o.rem  = cur[31:0];
         o.root = {s.root[29:0], 1'b0};
      end
      return o;
   endfunction

   function automatic logic [49:0] abs50(logic signed [49:0] v);
      return v[49] ? 50'(-v) : 50'(v);
   endfunction

   function automatic dv_type div_prep(logic signed [49:0] num, logic [47:0] den);
      dv_type      d;
      logic [49:0] mag;
      mag   = abs50(num);
      d.neg = num[49];
      d.fix = (mag == 50'd0) || (den == 48'd0) || (mag >= {2'b00, den});
      d.one = (mag != 50'd0);
      d.den = den;
      d.rem = mag[47:0];
      d.q   = '0;
      return d;
   endfunction

   function automatic logic div_clamp(logic signed [49:0] num, logic [47:0] den);
      logic [49:0] mag;
      mag = abs50(num);
      return (mag != 50'd0) && ((den == 48'd0) || (mag > {2'b00, den}));
   endfunction

   function automatic dv_type div_step(dv_type d);
      dv_type      o;
      logic [48:0] rem2;
      o    = d;
      rem2 = {d.rem, 1'b0};
      if (rem2 >= {1'b0, d.den}) begin
         o.rem = 48'(rem2 - {1'b0, d.den});
         o.q   = {d.q[28:0], 1'b1};
      end else begin
         o.rem = rem2[47:0];
         o.q   = {d.q[28:0], 1'b0};
      end
      return o;
   endfunction

   function automatic logic [30:0] div_mag(dv_type d);
      return d.fix ? {d.one, 30'd0} : {1'b0, d.q};
   endfunction

   function automatic logic signed [31:0] div_result(dv_type d);
      logic [31:0] m;
      m = {1'b0, div_mag(d)};
      return d.neg ? -$signed(m) : $signed(m);
   endfunction

   // atan(2^-i) in q3.28, rounded to nearest
   function automatic logic signed [31:0] atan_tab(logic [4:0] i);
      logic signed [31:0] v;
      case (i)
         5'd0:  v = 32'sd210828714;
         5'd1:  v = 32'sd124459457;
         5'd2:  v = 32'sd65760959;
         5'd3:  v = 32'sd33381290;
         5'd4:  v = 32'sd16755422;
         5'd5:  v = 32'sd8385879;
         5'd6:  v = 32'sd4193963;
         5'd7:  v = 32'sd2097109;
         5'd8:  v = 32'sd1048571;
         5'd9:  v = 32'sd524287;
         5'd10: v = 32'sd262144;
         5'd11: v = 32'sd131072;
         5'd12: v = 32'sd65536;
         5'd13: v = 32'sd32768;
         5'd14: v = 32'sd16384;
         5'd15: v = 32'sd8192;
         5'd16: v = 32'sd4096;
         5'd17: v = 32'sd2048;
         5'd18: v = 32'sd1024;
         5'd19: v = 32'sd512;
         5'd20: v = 32'sd256;
         5'd21: v = 32'sd128;
         5'd22: v = 32'sd64;
         5'd23: v = 32'sd32;
         5'd24: v = 32'sd16;
         5'd25: v = 32'sd8;
         5'd26: v = 32'sd4;
         5'd27: v = 32'sd2;
         default: v = 32'sd0;
      endcase
      return v;
   endfunction

   // quarter-turn into the right half plane
   function automatic cr_type cordic_pre(logic signed [59:0] x, logic signed [59:0] y);
      cr_type c;
      c.x = x;
      c.y = y;
      c.z = 32'sd0;
      if (x < 0) begin
         if (y >= 0) begin
            c.x = y;
            c.y = -x;
            c.z = HALF_PI_Q28;
         end else begin
            c.x = -y;
            c.y = x;
            c.z = -HALF_PI_Q28;
         end
      end
      return c;
   endfunction

   function automatic cr_type cordic_step(cr_type c, logic [4:0] i);
      cr_type             o;
      logic signed [59:0] dx;
      logic signed [59:0] dy;
      dx = c.y >>> i;
      dy = c.x >>> i;
      if (!c.y[59]) begin
         o.x = c.x + dx;
         o.y = c.y - dy;
         o.z = c.z + atan_tab(i);
      end else begin
         o.x = c.x - dx;
         o.y = c.y + dy;
         o.z = c.z - atan_tab(i);
      end
      return o;
   endfunction

   function automatic logic [29:0] acos_clamp(logic signed [31:0] z);
      if (z < 0)
         return 30'd0;
      if (z > PI_Q28)
         return PI_Q28[29:0];
      return z[29:0];
   endfunction

endpackage

// ===== hdl/scara_inverse_kinematics_unit.sv =====
// Inverse kinematics of a two-link planar arm. Each req transaction carries a target
// point (x, y) in 1/1024 mm; the matching rsp transaction returns the shoulder angle
// (signed q3.28, -pi..2pi), the elbow angle (q2.28, 0..pi) and an unreachable flag that
// is set when either arccosine argument had to be clamped to [-1, 1]. The link lengths
// are two registers the user must write through the csr port only while no transaction
// is in flight; the block does not enforce it. The datapath is a fully pipelined chain:
// products, a 24-step square root for the radius, two 30-step restoring dividers, two
// 31-step square roots for the arccosine legs and three 28-iteration cordic vectoring
// units, each step one register stage. One point is accepted every clock cycle while
// rsp is not stalled. A stalled rsp freezes the whole chain so nothing is dropped or
// repeated; results come out in order.
`include "assert_macros.svh"

module scara_inverse_kinematics_unit
   import sik_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // configuration writes
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [22:0] csr_wdata,
   // target point stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // target_x [23:0], target_y [47:24]
   // joint angle stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // shoulder_angle [31:0], elbow_angle [61:32], zero pad
   output logic        rsp_tuser    // unreachable
);

   // link length registers
   logic [22:0] upper_ff;
   logic [22:0] lower_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         upper_ff <= LINK_RESET;
         lower_ff <= LINK_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_UPPER: upper_ff <= csr_wdata;
            CSR_LOWER: lower_ff <= csr_wdata;
            default:   upper_ff <= upper_ff;
         endcase
      end
   end

   // whole chain moves together; it only holds when a result waits at the output
   logic adv;
   logic rsp_tvalid_ff;

   assign adv        = !rsp_tvalid_ff || rsp_tready;
   assign req_tready = adv;

   // stage: squares and link products
   mul_type mul_in;
   mul_type mul_ff;
   logic    mul_vld_ff;

   always_comb begin
      logic signed [47:0] xsq;
      logic signed [47:0] ysq;
      mul_in.pt.x = req_tdata[23:0];
      mul_in.pt.y = req_tdata[47:24];
      xsq         = mul_in.pt.x * mul_in.pt.x;
      ysq         = mul_in.pt.y * mul_in.pt.y;
      mul_in.xx   = xsq[46:0];
      mul_in.yy   = ysq[46:0];
      mul_in.aa   = upper_ff * upper_ff;
      mul_in.bb   = lower_ff * lower_ff;
      mul_in.ab   = upper_ff * lower_ff;
   end

   always_ff @(posedge clock) begin
      if (reset)
         mul_vld_ff <= 1'b0;
      else if (adv)
         mul_vld_ff <= req_tvalid;
   end

   always_ff @(posedge clock) begin
      if (adv)
         mul_ff <= mul_in;
   end

   // stage: r^2 and the two law-of-cosines numerators
   sum_type sum_in;
   sum_type sum_ff;
   logic    sum_vld_ff;

   always_comb begin
      sum_in.pt   = mul_ff.pt;
      sum_in.r2z  = (mul_ff.pt.x == 24'sd0) && (mul_ff.pt.y == 24'sd0);
      sum_in.r2   = {1'b0, mul_ff.xx} + {1'b0, mul_ff.yy};
      sum_in.num1 = $signed({4'b0, mul_ff.aa}) + $signed({4'b0, mul_ff.bb})
                    - $signed({2'b0, sum_in.r2});
      sum_in.num2 = $signed({4'b0, mul_ff.aa}) + $signed({2'b0, sum_in.r2})
                    - $signed({4'b0, mul_ff.bb});
      sum_in.den1 = {1'b0, mul_ff.ab, 1'b0};
   end

   always_ff @(posedge clock) begin
      if (reset)
         sum_vld_ff <= 1'b0;
      else if (adv)
         sum_vld_ff <= mul_vld_ff;
   end

   always_ff @(posedge clock) begin
      if (adv)
         sum_ff <= sum_in;
   end

   // radius square root, one result bit per stage
   rs_type rs_ff [R_STEPS];
   logic   rs_vld_ff [R_STEPS];

   for (genvar k = 0; k < R_STEPS; k++) begin : g_rsq
      rs_type src;
      logic   src_vld;
      rs_type stage_in;
      if (k == 0) begin : g_head
         always_comb begin
            src.pt      = sum_ff.pt;
            src.r2z     = sum_ff.r2z;
            src.num1    = sum_ff.num1;
            src.num2    = sum_ff.num2;
            src.den1    = sum_ff.den1;
            // radicand left aligned so 24 steps consume all of r^2
            src.sq.rad  = {sum_ff.r2, 14'd0};
            src.sq.rem  = '0;
            src.sq.root = '0;
            src_vld     = sum_vld_ff;
         end
      end else begin : g_body
         assign src     = rs_ff[k-1];
         assign src_vld = rs_vld_ff[k-1];
      end
      always_comb begin
         stage_in    = src;
         stage_in.sq = sqrt_step(src.sq);
      end
      always_ff @(posedge clock) begin
         if (reset)
            rs_vld_ff[k] <= 1'b0;
         else if (adv)
            rs_vld_ff[k] <= src_vld;
      end
      always_ff @(posedge clock) begin
         if (adv)
            rs_ff[k] <= stage_in;
      end
   end

   // stage: shoulder divisor 2*a*r
   dn_type dn_in;
   dn_type dn_ff;
   logic   dn_vld_ff;

   always_comb begin
      logic [46:0] ar;
      ar         = upper_ff * rs_ff[R_STEPS-1].sq.root[23:0];
      dn_in.pt   = rs_ff[R_STEPS-1].pt;
      dn_in.r2z  = rs_ff[R_STEPS-1].r2z;
      dn_in.num1 = rs_ff[R_STEPS-1].num1;
      dn_in.num2 = rs_ff[R_STEPS-1].num2;
      dn_in.den1 = rs_ff[R_STEPS-1].den1;
      dn_in.den2 = {ar, 1'b0};
   end

   always_ff @(posedge clock) begin
      if (reset)
         dn_vld_ff <= 1'b0;
      else if (adv)
         dn_vld_ff <= rs_vld_ff[R_STEPS-1];
   end

   always_ff @(posedge clock) begin
      if (adv)
         dn_ff <= dn_in;
   end

   // dividers: slot 0 sorts out the early-out cases, then one quotient bit per stage
   ds_type ds_ff [DIV_STEPS+1];
   logic   ds_vld_ff [DIV_STEPS+1];

   for (genvar k = 0; k <= DIV_STEPS; k++) begin : g_div
      ds_type stage_in;
      logic   src_vld;
      if (k == 0) begin : g_head
         always_comb begin
            stage_in.pt    = dn_ff.pt;
            stage_in.r2z   = dn_ff.r2z;
            stage_in.clamp = div_clamp(dn_ff.num1, dn_ff.den1)
                             || div_clamp(dn_ff.num2, dn_ff.den2);
            stage_in.d1    = div_prep(dn_ff.num1, dn_ff.den1);
            stage_in.d2    = div_prep(dn_ff.num2, dn_ff.den2);
            src_vld        = dn_vld_ff;
         end
      end else begin : g_body
         always_comb begin
            stage_in    = ds_ff[k-1];
            stage_in.d1 = div_step(ds_ff[k-1].d1);
            stage_in.d2 = div_step(ds_ff[k-1].d2);
            src_vld     = ds_vld_ff[k-1];
         end
      end
      always_ff @(posedge clock) begin
         if (reset)
            ds_vld_ff[k] <= 1'b0;
         else if (adv)
            ds_vld_ff[k] <= src_vld;
      end
      always_ff @(posedge clock) begin
         if (adv)
            ds_ff[k] <= stage_in;
      end
   end

   // stage: signed q1.30 arguments and their squares
   tq_type tq_in;
   tq_type tq_ff;
   logic   tq_vld_ff;

   always_comb begin
      logic [30:0] m1;
      logic [30:0] m2;
      m1           = div_mag(ds_ff[DIV_STEPS].d1);
      m2           = div_mag(ds_ff[DIV_STEPS].d2);
      tq_in.pt     = ds_ff[DIV_STEPS].pt;
      tq_in.r2z    = ds_ff[DIV_STEPS].r2z;
      tq_in.clamp  = ds_ff[DIV_STEPS].clamp;
      tq_in.t1     = div_result(ds_ff[DIV_STEPS].d1);
      tq_in.t2     = div_result(ds_ff[DIV_STEPS].d2);
      tq_in.tt1    = m1 * m1;
      tq_in.tt2    = m2 * m2;
   end

   always_ff @(posedge clock) begin
      if (reset)
         tq_vld_ff <= 1'b0;
      else if (adv)
         tq_vld_ff <= ds_vld_ff[DIV_STEPS];
   end

   always_ff @(posedge clock) begin
      if (adv)
         tq_ff <= tq_in;
   end

   // sqrt(1 - t^2) for both arccosines
   as_type as_ff [ACOS_STEPS];
   logic   as_vld_ff [ACOS_STEPS];

   for (genvar k = 0; k < ACOS_STEPS; k++) begin : g_asq
      as_type src;
      logic   src_vld;
      as_type stage_in;
      if (k == 0) begin : g_head
         always_comb begin
            src.pt      = tq_ff.pt;
            src.r2z     = tq_ff.r2z;
            src.clamp   = tq_ff.clamp;
            src.t1      = tq_ff.t1;
            src.t2      = tq_ff.t2;
            src.s1.rad  = (tq_ff.tt1 >= ONE_Q60) ? 62'd0 : ONE_Q60 - tq_ff.tt1;
            src.s1.rem  = '0;
            src.s1.root = '0;
            src.s2.rad  = (tq_ff.tt2 >= ONE_Q60) ? 62'd0 : ONE_Q60 - tq_ff.tt2;
            src.s2.rem  = '0;
            src.s2.root = '0;
            src_vld     = tq_vld_ff;
         end
      end else begin : g_body
         assign src     = as_ff[k-1];
         assign src_vld = as_vld_ff[k-1];
      end
      always_comb begin
         stage_in    = src;
         stage_in.s1 = sqrt_step(src.s1);
         stage_in.s2 = sqrt_step(src.s2);
      end
      always_ff @(posedge clock) begin
         if (reset)
            as_vld_ff[k] <= 1'b0;
         else if (adv)
            as_vld_ff[k] <= src_vld;
      end
      always_ff @(posedge clock) begin
         if (adv)
            as_ff[k] <= stage_in;
      end
   end

   // three cordic vectoring units side by side: elbow acos, shoulder acos, polar angle
   cs_type cs_ff [CORDIC_STEPS+1];
   logic   cs_vld_ff [CORDIC_STEPS+1];

   for (genvar k = 0; k <= CORDIC_STEPS; k++) begin : g_cor
      cs_type stage_in;
      logic   src_vld;
      if (k == 0) begin : g_head
         always_comb begin
            as_type h;
            h              = as_ff[ACOS_STEPS-1];
            stage_in.r2z   = h.r2z;
            stage_in.clamp = h.clamp;
            // operands scaled by 2^26 before the first rotation
            stage_in.c1    = cordic_pre({{2{h.t1[31]}}, h.t1, 26'd0},
                                        {3'b000, h.s1.root, 26'd0});
            stage_in.c2    = cordic_pre({{2{h.t2[31]}}, h.t2, 26'd0},
                                        {3'b000, h.s2.root, 26'd0});
            stage_in.c3    = cordic_pre({{10{h.pt.x[23]}}, h.pt.x, 26'd0},
                                        {{10{h.pt.y[23]}}, h.pt.y, 26'd0});
            src_vld        = as_vld_ff[ACOS_STEPS-1];
         end
      end else begin : g_body
         always_comb begin
            stage_in    = cs_ff[k-1];
            stage_in.c1 = cordic_step(cs_ff[k-1].c1, 5'(k-1));
            stage_in.c2 = cordic_step(cs_ff[k-1].c2, 5'(k-1));
            stage_in.c3 = cordic_step(cs_ff[k-1].c3, 5'(k-1));
            src_vld     = cs_vld_ff[k-1];
         end
      end
      always_ff @(posedge clock) begin
         if (reset)
            cs_vld_ff[k] <= 1'b0;
         else if (adv)
            cs_vld_ff[k] <= src_vld;
      end
      always_ff @(posedge clock) begin
         if (adv)
            cs_ff[k] <= stage_in;
      end
   end

   // output register: final angle arithmetic
   logic signed [31:0] rsp_shoulder_in;
   logic [29:0]        rsp_elbow_in;
   logic signed [31:0] rsp_shoulder_ff;
   logic [29:0]        rsp_elbow_ff;
   logic               rsp_unreach_ff;

   always_comb begin
      logic [29:0]        acos1;
      logic [29:0]        acos2;
      logic signed [31:0] polar;
      cs_type             t;
      t     = cs_ff[CORDIC_STEPS];
      acos1 = acos_clamp(t.c1.z);
      acos2 = acos_clamp(t.c2.z);
      // polar angle folded into [0, 2pi), zero at the origin
      if (t.r2z)
         polar = 32'sd0;
      else if (t.c3.z < 0)
         polar = t.c3.z + TWO_PI_Q28;
      else
         polar = t.c3.z;
      rsp_elbow_in    = PI_Q28[29:0] - acos1;
      rsp_shoulder_in = polar - $signed({2'b00, acos2});
   end

   always_ff @(posedge clock) begin
      if (reset)
         rsp_tvalid_ff <= 1'b0;
      else if (adv)
         rsp_tvalid_ff <= cs_vld_ff[CORDIC_STEPS];
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_shoulder_ff <= rsp_shoulder_in;
         rsp_elbow_ff    <= rsp_elbow_in;
         rsp_unreach_ff  <= cs_ff[CORDIC_STEPS].clamp;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = {2'b00, rsp_elbow_ff, rsp_shoulder_ff};
   assign rsp_tuser  = rsp_unreach_ff;

   // divider output must be a legal arccosine argument
   `SIK_ASSERT_IMP(a_ratio_range, tq_vld_ff, (tq_ff.t1 <= ONE_Q30) && (tq_ff.t1 >= -ONE_Q30) && (tq_ff.t2 <= ONE_Q30) && (tq_ff.t2 >= -ONE_Q30))
   // sqrt(1 - t^2) never exceeds one
   `SIK_ASSERT_IMP(a_leg_range, as_vld_ff[ACOS_STEPS-1], (as_ff[ACOS_STEPS-1].s1.root <= 31'h4000_0000) && (as_ff[ACOS_STEPS-1].s2.root <= 31'h4000_0000))
   // a finished item in the last cordic slot survives a stall
   `SIK_ASSERT_NXT(a_stall_keeps, cs_vld_ff[CORDIC_STEPS] && !adv, cs_vld_ff[CORDIC_STEPS])
   // elbow result stays within [0, pi]
   `SIK_ASSERT_IMP(a_elbow_range, rsp_tvalid_ff, rsp_elbow_ff <= PI_Q28[29:0])

endmodule

// ===== dv/tb.sv =====
`default_nettype none

module tb
   import sik_pkg::*;
;

   timeunit 1ns;
   timeprecision 1ps;

   // packed lowest field last so target_x lands in req_tdata[23:0]
   typedef struct packed {
      logic signed [23:0] y;
      logic signed [23:0] x;
   } point_t;

   typedef struct packed {
      logic signed [31:0] shoulder;
      logic [29:0]        elbow;
      logic               unreachable;
   } joints_t;

   logic        clock;
   logic        reset;
   logic        csr_we;
   logic        csr_index;
   logic [22:0] csr_wdata;
   logic        req_tvalid;
   logic        req_tready;
   logic [47:0] req_tdata;   // target_x [23:0], target_y [47:24]
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [63:0] rsp_tdata;   // shoulder_angle [31:0], elbow_angle [61:32], zero pad
   logic        rsp_tuser;   // unreachable

   scara_inverse_kinematics_unit u_dut (.*);

   // testbench copy of the link lengths
   longint upper_len = LINK_RESET;
   longint lower_len = LINK_RESET;

   point_t  target_q[$];     // points still to be offered
   joints_t joint_q[$];      // predicted angles, oldest first
   int      tx_idle_pct = 0;
   int      rx_idle_pct = 0;
   int      errors = 0;
   int      n_points = 0;
   int      n_angles = 0;
   int      n_unreach = 0;
   int      idle_cycles = 0;
   bit      req_fire = 0;
   bit      stall_go = 0;
   bit      stall_done = 0;
   int      stall_cnt = 0;

   // ---------------------------------------------------------------- predictor

   function automatic longint unsigned int_sqrt(longint unsigned v);
      longint unsigned res;
      longint unsigned b;
      res = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= res + b) begin
            v = v - (res + b);
            res = (res >> 1) + b;
         end else begin
            res = res >> 1;
         end
         b = b >> 2;
      end
      return res;
   endfunction

   // q1.30 quotient, clamped to +-1; a clamp marks the point unreachable
   function automatic longint cos_ratio(longint num, longint unsigned den, inout bit clamped);
      bit              neg;
      longint unsigned mag;
      longint unsigned rem;
      longint unsigned q;
      neg = num < 0;
      mag = neg ? -num : num;
      q = 0;
      if (mag == 0) return 0;
      if (den == 0 || mag > den) begin
         clamped = 1;
         return neg ? -longint'(ONE_Q30) : longint'(ONE_Q30);
      end
      // exact +-1 passes without a flag
      if (mag == den) return neg ? -longint'(ONE_Q30) : longint'(ONE_Q30);
      rem = mag;
      for (int i = 0; i < 30; i++) begin
         rem = rem << 1;
         q = q << 1;
         if (rem >= den) begin
            rem = rem - den;
            q = q | 1;
         end
      end
      return neg ? -longint'(q) : longint'(q);
   endfunction

   function automatic longint atan_step(int i);
      longint steps[28] = '{210828714, 124459457, 65760959, 33381290, 16755422, 8385879,
                            4193963, 2097109, 1048571, 524287, 262144, 131072, 65536,
                            32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128, 64, 32,
                            16, 8, 4, 2};
      return steps[i];
   endfunction

   function automatic longint vector_angle(longint x, longint y);
      longint z;
      longint t;
      longint dx;
      longint dy;
      z = 0;
      x = x * 64'sd67108864;
      y = y * 64'sd67108864;
      // left half plane: quarter turn first
      if (x < 0) begin
         t = x;
         if (y >= 0) begin
            x = y;
            y = -t;
            z = HALF_PI_Q28;
         end else begin
            x = -y;
            y = t;
            z = -longint'(HALF_PI_Q28);
         end
      end
      for (int i = 0; i < 28; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (y >= 0) begin
            x = x + dx;
            y = y - dy;
            z = z + longint'(atan_step(i));
         end else begin
            x = x - dx;
            y = y + dy;
            z = z - longint'(atan_step(i));
         end
      end
      return z;
   endfunction

   function automatic longint arc_cos(longint t);
      longint unsigned tt;
      longint unsigned one;
      longint          s;
      longint          z;
      tt = t * t;
      one = 64'd1 << 60;
      s = int_sqrt(tt >= one ? 0 : one - tt);
      z = vector_angle(t, s);
      if (z < 0) z = 0;
      if (z > PI_Q28) z = PI_Q28;
      return z;
   endfunction

   function automatic joints_t joint_angles(point_t p);
      joints_t j;
      longint  x;
      longint  y;
      longint  r2;
      longint  r;
      longint  c;
      longint  beta;
      longint  polar;
      longint  alpha;
      bit      clamped;
      x = p.x;
      y = p.y;
      clamped = 0;
      r2 = x * x + y * y;
      r = int_sqrt(r2);
      c = cos_ratio(upper_len * upper_len + lower_len * lower_len - r2,
                    2 * upper_len * lower_len, clamped);
      beta = PI_Q28 - arc_cos(c);
      // the origin has no direction: polar angle 0
      polar = 0;
      if (r2 != 0) begin
         polar = vector_angle(x, y);
         if (polar < 0) polar = polar + TWO_PI_Q28;
      end
      c = cos_ratio(upper_len * upper_len + r2 - lower_len * lower_len,
                    2 * upper_len * r, clamped);
      alpha = polar - arc_cos(c);
      j.shoulder = alpha[31:0];
      j.elbow = beta[29:0];
      j.unreachable = clamped;
      return j;
   endfunction

   // ------------------------------------------------------------ clock, reset

   initial begin
      clock = 0;
      forever #2 clock = ~clock;
   end

   initial begin
      reset = 1;
      repeat (12) @(posedge clock);
      reset <= 0;
   end

   // ------------------------------------------------------------------ driver

   // sender: hold an offered point until it is taken, then maybe idle
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 0;
         req_tdata  <= '0;
      end else if (!req_tvalid || req_fire) begin
         if (target_q.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
            req_tvalid <= 1;
            req_tdata  <= target_q.pop_front();
         end else begin
            req_tvalid <= 0;
         end
      end
   end

   // receiver: random backpressure, plus one long hold-off on request
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 0;
      end else if (stall_go && !stall_done) begin
         rsp_tready <= 0;
         stall_cnt++;
         if (stall_cnt == 600) stall_done = 1;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rx_idle_pct);
      end
   end

   // ----------------------------------------------------------------- monitor

   task automatic report(string what, longint got, longint want);
      errors++;
      $display("error: %s got %0d want %0d (transaction %0d)", what, got, want, n_angles);
   endtask

   always @(posedge clock) begin
      joints_t want;
      req_fire <= req_tvalid && req_tready;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            joint_q.push_back(joint_angles(req_tdata));
            n_points++;
         end
         if (rsp_tvalid && rsp_tready) begin
            if (joint_q.size() == 0) begin
               report("unexpected rsp transaction", 0, 0);
            end else begin
               want = joint_q.pop_front();
               if ($signed(rsp_tdata[31:0]) != want.shoulder)
                  report("shoulder_angle", $signed(rsp_tdata[31:0]), want.shoulder);
               if (rsp_tdata[61:32] != want.elbow)
                  report("elbow_angle", rsp_tdata[61:32], want.elbow);
               if (rsp_tuser != want.unreachable)
                  report("unreachable", rsp_tuser, want.unreachable);
               if (want.unreachable) n_unreach++;
            end
            n_angles++;
         end
         // watchdog on cycles with no transaction anywhere
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;
         if (idle_cycles > 20000) begin
            $display("timeout: no transaction for too long");
            $display("scara_inverse_kinematics_unit: mismatch");
            $finish;
         end
      end
   end

   // ----------------------------------------------------------------- stimulus

   task automatic drain();
      wait (target_q.size() == 0 && !req_tvalid && joint_q.size() == 0);
      // pipeline is 120 deep; leave margin before touching the link lengths
      repeat (140) @(posedge clock);
   endtask

   task automatic set_links(logic [22:0] a, logic [22:0] b);
      @(negedge clock);
      csr_we    <= 1;
      csr_index <= CSR_UPPER;
      csr_wdata <= a;
      @(negedge clock);
      csr_index <= CSR_LOWER;
      csr_wdata <= b;
      @(negedge clock);
      csr_we <= 0;
      upper_len = a;
      lower_len = b;
   endtask

   task automatic add_point(longint x, longint y);
      point_t p;
      p.x = x[23:0];
      p.y = y[23:0];
      target_q.push_back(p);
   endtask

   // mostly points near the workspace, some anywhere in the field range
   task automatic add_random(int n);
      longint reach;
      longint x;
      longint y;
      reach = upper_len + lower_len;
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(2) == 0 || reach > 8388607) begin
            x = $signed(24'($urandom)) >>> $urandom_range(14);
            y = $signed(24'($urandom)) >>> $urandom_range(14);
         end else begin
            x = longint'($urandom_range(2 * reach)) - reach;
            y = longint'($urandom_range(2 * reach)) - reach;
            if ($urandom_range(9) == 0) x = 0;
            if ($urandom_range(9) == 0) y = 0;
         end
         add_point(x, y);
      end
   endtask

   initial begin
      csr_we    = 0;
      csr_index = CSR_UPPER;
      csr_wdata = '0;
      @(negedge clock);
      wait (!reset);

      // phase 1: reset link lengths, corners and reach limits
      set_links(23'd204800, 23'd204800);
      tx_idle_pct = 8;
      rx_idle_pct = 72;
      add_point(0, 0);                     // origin, zero radius divisor
      add_point(-8388608, -8388608);
      add_point(8388607, 8388607);
      add_point(-8388608, 8388607);
      add_point(8388607, -8388608);
      add_point(409600, 0);                // fully stretched, cosine exactly -1
      add_point(0, -409600);
      add_point(409601, 0);                // just out of reach
      add_point(-409600, 0);
      add_point(1, 0);
      add_point(0, 1);
      add_point(-1, -1);
      add_point(204800, 204800);
      add_point(-204800, 100);
      add_point(-204800, -100);
      add_point(0, -1);
      add_random(480);
      drain();

      // phase 2: lopsided links, swapped idling, long receiver hold-off
      set_links(23'd8388607, 23'd1);
      tx_idle_pct = 72;
      rx_idle_pct = 8;
      add_point(0, 0);                     // origin with unequal links: clamped
      add_point(8388607, 0);
      add_point(-8388608, 0);
      add_random(150);
      wait (target_q.size() == 0);
      tx_idle_pct = 0;
      stall_go = 1;
      add_random(250);
      drain();

      // phase 3: the other way round, then random lengths, no idling
      set_links(23'd1, 23'd8388607);
      tx_idle_pct = 0;
      rx_idle_pct = 0;
      add_point(0, 0);
      add_point(-8388608, -8388608);
      add_random(200);
      drain();
      set_links(23'($urandom_range(300000, 1)), 23'($urandom_range(300000, 1)));
      add_random(400);
      drain();

      $display("covered %0d points over four link settings, %0d flagged unreachable",
               n_points, n_unreach);
      $display("checked %0d angle results with idling on both sides and a long stall",
               n_angles);
      if (errors == 0)
         $display("scara_inverse_kinematics_unit: match");
      else
         $display("scara_inverse_kinematics_unit: mismatch");
      $finish;
   end

endmodule

`default_nettype wire
